FILE: rtl/core/gtrb_pkg.sv
// Shared types, widths and the arctangent table for the range and bearing pipeline.
package gtrb_pkg;

    localparam int VEC_W = 54;
    localparam int ANG_W = 37;
    localparam int SQ_W = 64;
    localparam int SQRT_STEPS = 32;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int IN_W = 192;
    localparam int OUT_W = 48;

    localparam logic signed [ANG_W-1:0] ANG_PI = 37'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_2PI = 37'sd6746518852;

    typedef struct packed {
        logic                    valid;
        logic                    dzero;
        logic                    yzero;
        logic signed [VEC_W-1:0] dxv;
        logic signed [VEC_W-1:0] dyv;
        logic signed [VEC_W-1:0] yxv;
        logic signed [VEC_W-1:0] yyv;
        logic signed [ANG_W-1:0] dz;
        logic signed [ANG_W-1:0] yz;
        logic [SQ_W-1:0]         rem;
        logic [SQ_W-1:0]         root;
    } pipe_t;

    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [ANG_W-1:0] v;
        unique case (i)
            5'd0:  v = 37'sd843314857;
            5'd1:  v = 37'sd497837829;
            5'd2:  v = 37'sd263043837;
            5'd3:  v = 37'sd133525159;
            5'd4:  v = 37'sd67021687;
            5'd5:  v = 37'sd33543516;
            5'd6:  v = 37'sd16775851;
            5'd7:  v = 37'sd8388437;
            5'd8:  v = 37'sd4194283;
            5'd9:  v = 37'sd2097149;
            5'd31: v = 37'sd0;
            default: v = ANG_W'(64'sd1 << (30 - i));
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/global_to_range_bearing.sv
// Range and bearing of a target in the platform frame: pipelined top level.
//
// Input words on s_tvalid/s_tready/s_tdata carry the target and platform
// global positions (1/256 m) and the platform quaternion (Q1.14). Each word
// produces one output word on m_tvalid/m_tready/m_tdata with the range
// (1/256 m, rounded) and the bearing in the platform frame (rad, Q3.13).
// The pipeline has three front stages (differences and products, squares
// and yaw terms, CORDIC pre-rotation), 32 step stages that each take one
// square root digit and, below CORDIC_STAGES, one CORDIC iteration on both
// vectors, and two back stages (wrap, round and output register).
// Throughput is one word per cycle unless the output stalls. All stages
// advance together; when the output word is held by the receiver the
// whole pipeline freezes and s_tready drops, so no word is lost or repeated.
// Reset clears every valid bit; the first word is taken the cycle after
// aresetn rises.
module global_to_range_bearing import gtrb_pkg::*; #(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // target_x, target_y, own_x, own_y, quat_w, quat_x, quat_y, quat_z, zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // range_out, bearing_out
    output logic [OUT_W-1:0] m_tdata
);

    logic  en;
    pipe_t chain [SQRT_STEPS+1];

    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    gtrb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .q        (chain[0])
    );

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
        gtrb_step #(
            .STAGE         (g),
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d       (chain[g]),
            .q       (chain[g+1])
        );
    end

    gtrb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .d         (chain[SQRT_STEPS]),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

    a_bearing_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[47:32]) >= -16'sd25736
                   && $signed(m_tdata[47:32]) <= 16'sd25736))
        else $error("bearing out of range");

    a_zero_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[31:0] == 32'd0) |-> m_tdata[47:32] == 16'd0)
        else $error("zero range with nonzero bearing");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

FILE: rtl/core/gtrb_front.sv
// Front end: differences, quaternion products, squares and CORDIC pre-rotation.
module gtrb_front import gtrb_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [IN_W-1:0]  in_data,
    output pipe_t            q
);

    logic               v1_reg, v2_reg;
    logic signed [31:0] dx1_reg, dy1_reg, pwz_reg, pxy_reg, pyy_reg, pzz_reg;
    logic signed [31:0] dx2_reg, dy2_reg;
    logic signed [33:0] ya2_reg, yb2_reg;
    logic [SQ_W-1:0]    sqx2_reg, sqy2_reg;
    logic               dzero2_reg, yzero2_reg;
    pipe_t              q_reg, q_next;

    logic signed [30:0] tx, ty, ox, oy;
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [33:0] ya_next, yb_next;
    logic [31:0]        adx, ady;
    logic signed [VEC_W-1:0] dxs, dys, yxs, yys;

    assign tx = $signed(in_data[30:0]);
    assign ty = $signed(in_data[61:31]);
    assign ox = $signed(in_data[92:62]);
    assign oy = $signed(in_data[123:93]);
    assign qw = $signed(in_data[139:124]);
    assign qx = $signed(in_data[155:140]);
    assign qy = $signed(in_data[171:156]);
    assign qz = $signed(in_data[187:172]);

    assign ya_next = (34'(pwz_reg) + 34'(pxy_reg)) <<< 1;
    assign yb_next = 34'sd268435456 - ((34'(pyy_reg) + 34'(pzz_reg)) <<< 1);
    assign adx = dx1_reg[31] ? 32'(-dx1_reg) : 32'(dx1_reg);
    assign ady = dy1_reg[31] ? 32'(-dy1_reg) : 32'(dy1_reg);

    assign dxs = {VEC_W'(dx2_reg)} <<< 16;
    assign dys = {VEC_W'(dy2_reg)} <<< 16;
    assign yxs = {VEC_W'(yb2_reg)} <<< 16;
    assign yys = {VEC_W'(ya2_reg)} <<< 16;

    always_comb begin
        q_next = '0;
        q_next.valid = v2_reg;
        q_next.dzero = dzero2_reg;
        q_next.yzero = yzero2_reg;
        q_next.rem = sqx2_reg + sqy2_reg;
        q_next.root = '0;
        if (dxs < 0) begin
            q_next.dxv = -dxs;
            q_next.dyv = -dys;
            q_next.dz = (dys >= 0) ? ANG_PI : -ANG_PI;
        end else begin
            q_next.dxv = dxs;
            q_next.dyv = dys;
            q_next.dz = '0;
        end
        if (yxs < 0) begin
            q_next.yxv = -yxs;
            q_next.yyv = -yys;
            q_next.yz = (yys >= 0) ? ANG_PI : -ANG_PI;
        end else begin
            q_next.yxv = yxs;
            q_next.yyv = yys;
            q_next.yz = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            q_reg.valid <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            q_reg <= q_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg <= 32'(tx) - 32'(ox);
            dy1_reg <= 32'(ty) - 32'(oy);
            pwz_reg <= qw * qz;
            pxy_reg <= qx * qy;
            pyy_reg <= qy * qy;
            pzz_reg <= qz * qz;
            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
            ya2_reg <= ya_next;
            yb2_reg <= yb_next;
            sqx2_reg <= SQ_W'(adx) * SQ_W'(adx);
            sqy2_reg <= SQ_W'(ady) * SQ_W'(ady);
            dzero2_reg <= (dx1_reg == 32'sd0) && (dy1_reg == 32'sd0);
            yzero2_reg <= (ya_next == 34'sd0) && (yb_next == 34'sd0);
        end
    end

    assign q = q_reg;

endmodule

FILE: rtl/core/gtrb_step.sv
// One stage: a sqrt digit and, if ACTIVE, a CORDIC vectoring step on both vectors.
module gtrb_step import gtrb_pkg::*; #(
    parameter int STAGE = 0,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  pipe_t d,
    output pipe_t q
);

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (62 - 2 * STAGE);
    localparam bit ACTIVE = STAGE < CORDIC_STAGES;

    pipe_t q_reg, q_next;
    logic signed [ANG_W-1:0] at;
    logic [SQ_W-1:0] trial;

    assign at = atan_entry(5'(STAGE));
    assign trial = d.root + BIT;

    always_comb begin
        q_next = d;
        if (d.rem >= trial) begin
            q_next.rem = d.rem - trial;
            q_next.root = (d.root >> 1) + BIT;
        end else begin
            q_next.root = d.root >> 1;
        end
        if (ACTIVE) begin
            if (d.dyv < 0) begin
                q_next.dxv = d.dxv - (d.dyv >>> STAGE);
                q_next.dyv = d.dyv + (d.dxv >>> STAGE);
                q_next.dz = d.dz - at;
            end else begin
                q_next.dxv = d.dxv + (d.dyv >>> STAGE);
                q_next.dyv = d.dyv - (d.dxv >>> STAGE);
                q_next.dz = d.dz + at;
            end
            if (d.yyv < 0) begin
                q_next.yxv = d.yxv - (d.yyv >>> STAGE);
                q_next.yyv = d.yyv + (d.yxv >>> STAGE);
                q_next.yz = d.yz - at;
            end else begin
                q_next.yxv = d.yxv + (d.yyv >>> STAGE);
                q_next.yyv = d.yyv - (d.yxv >>> STAGE);
                q_next.yz = d.yz + at;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
        end else if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: rtl/core/gtrb_back.sv
// Back end: range rounding, angle difference and wrap, bearing rounding, output register.
module gtrb_back import gtrb_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  pipe_t            d,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_data
);

    logic                    v1_reg, dzero1_reg, out_valid_reg;
    logic [31:0]             range1_reg;
    logic signed [ANG_W-1:0] a1_reg;
    logic [OUT_W-1:0]        out_data_reg;
    logic signed [ANG_W-1:0] a0, a1_next, a2, rnd;
    logic [15:0]             bearing;

    always_comb begin
        a0 = d.dz - (d.yzero ? ANG_W'(0) : d.yz);
        if (a0 > ANG_PI) begin
            a1_next = a0 - ANG_2PI;
        end else if (a0 <= -ANG_PI) begin
            a1_next = a0 + ANG_2PI;
        end else begin
            a1_next = a0;
        end
        if (a1_reg > ANG_PI) begin
            a2 = a1_reg - ANG_2PI;
        end else if (a1_reg <= -ANG_PI) begin
            a2 = a1_reg + ANG_2PI;
        end else begin
            a2 = a1_reg;
        end
        rnd = (a2 + ANG_W'(65536)) >>> 17;
        bearing = dzero1_reg ? 16'd0 : rnd[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= d.valid;
            out_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            range1_reg <= (d.rem > d.root) ? 32'(d.root + 1'b1) : 32'(d.root);
            dzero1_reg <= d.dzero;
            a1_reg <= a1_next;
            out_data_reg <= {bearing, range1_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule
